@@ src/ansi_terminal_escape_engine_top_defines.svh @@
// assertion macros for the terminal engine
`ifndef ANSI_TERMINAL_ESCAPE_ENGINE_TOP_DEFINES_SVH
`define ANSI_TERMINAL_ESCAPE_ENGINE_TOP_DEFINES_SVH
`ifndef SYNTH
`define ATE_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("same-cycle check failed");
`define ATE_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");
`else
`define ATE_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define ATE_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

@@ src/ate_pkg.sv @@
package ate_pkg;

    localparam int ROWS_DEF = 32;
    localparam int COLS_DEF = 128;

    localparam logic [7:0] CH_BEL      = 8'h07;
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0a;
    localparam logic [7:0] CH_CR       = 8'h0d;
    localparam logic [7:0] CH_ESC      = 8'h1b;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TILDE    = 8'h7e;
    localparam logic [7:0] CH_0        = 8'h30;
    localparam logic [7:0] CH_9        = 8'h39;
    localparam logic [7:0] CH_SEMI     = 8'h3b;
    localparam logic [7:0] CH_UA       = 8'h41;
    localparam logic [7:0] CH_UZ       = 8'h5a;
    localparam logic [7:0] CH_LA       = 8'h61;
    localparam logic [7:0] CH_LZ       = 8'h7a;
    localparam logic [7:0] CH_LBRACKET = 8'h5b;
    localparam logic [7:0] CH_RBRACKET = 8'h5d;

    localparam logic [7:0] CSI_UP    = 8'h41;
    localparam logic [7:0] CSI_DOWN  = 8'h42;
    localparam logic [7:0] CSI_RIGHT = 8'h43;
    localparam logic [7:0] CSI_LEFT  = 8'h44;
    localparam logic [7:0] CSI_COL   = 8'h47;
    localparam logic [7:0] CSI_POS   = 8'h48;
    localparam logic [7:0] CSI_CLEAR = 8'h4a;
    localparam logic [7:0] CSI_ERASE = 8'h4b;
    localparam logic [7:0] CSI_DEL   = 8'h50;
    localparam logic [7:0] CSI_ROW   = 8'h64;
    localparam logic [7:0] CSI_SGR   = 8'h6d;

    localparam logic [3:0] COLOUR_DEFAULT = 4'd9;
    localparam logic [15:0] PARAM_MAX = 16'hffff;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_CSI    = 2'd2,
        MODE_OSC    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_SIMPLE,
        KIND_READ,
        KIND_PUT,
        KIND_DEL
    } kind_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_SIMPLE,
        CMD_READ,
        CMD_PUT_START,
        CMD_PAD_STEP,
        CMD_PUT_FINAL,
        CMD_DEL_START,
        CMD_SHIFT_RD,
        CMD_SHIFT_WR,
        CMD_DEL_FINAL
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_PAD,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_READ_DATA,
        S_WAIT_OUT
    } ctrl_state_t;

    typedef struct packed {
        cmd_t op;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  pad_needed;
        logic  pad_more;
        logic  del_needed;
        logic  shift_more;
        logic  out_free;
    } dp_status_t;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [1:0]  parse_state;
        logic [7:0]  cell_char;
        logic [23:0] cell_fg;
        logic [23:0] cell_bg;
        logic        cell_present;
    } out_item_t;

    function automatic logic [23:0] colour_rgb(input logic [3:0] idx, input logic fg);
        logic [23:0] rgb;
        begin
            case (idx)
                4'd0:    rgb = 24'h000000;
                4'd1:    rgb = 24'hc91b00;
                4'd2:    rgb = 24'h00c200;
                4'd3:    rgb = 24'hc7c400;
                4'd4:    rgb = 24'h0225c7;
                4'd5:    rgb = 24'hc930c7;
                4'd6:    rgb = 24'h00c5c7;
                4'd7:    rgb = 24'hc7c7c7;
                default: rgb = fg ? 24'hc7c7c7 : 24'h000000;
            endcase
            return rgb;
        end
    endfunction

endpackage

@@ src/ate_ram.sv @@
module ate_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/ate_ctrl.sv @@
module ate_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ate_pkg::dp_status_t status,
    output ate_pkg::dp_cmd_t    cmd
);

    import ate_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (status.kind)
                    KIND_READ: state_next = S_READ_DATA;
                    KIND_PUT:
                    begin
                        if (status.pad_needed)
                        begin
                            state_next = S_PAD;
                        end
                        else
                        begin
                            state_next = status.out_free ? S_IDLE : S_WAIT_OUT;
                        end
                    end
                    KIND_DEL:
                    begin
                        if (status.del_needed)
                        begin
                            state_next = S_SHIFT_RD;
                        end
                        else
                        begin
                            state_next = status.out_free ? S_IDLE : S_WAIT_OUT;
                        end
                    end
                    default: state_next = status.out_free ? S_IDLE : S_WAIT_OUT;
                endcase
            end
            S_PAD:
            begin
                if (!status.pad_more)
                begin
                    state_next = status.out_free ? S_IDLE : S_WAIT_OUT;
                end
            end
            S_SHIFT_RD:
            begin
                if (status.shift_more)
                begin
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    state_next = status.out_free ? S_IDLE : S_WAIT_OUT;
                end
            end
            S_SHIFT_WR: state_next = S_SHIFT_RD;
            S_READ_DATA: state_next = status.out_free ? S_IDLE : S_WAIT_OUT;
            S_WAIT_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        cmd.op = CMD_NONE;
        cmd.load_out = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op = CMD_LATCH;
                end
            end
            S_DISPATCH:
            begin
                case (status.kind)
                    KIND_READ: cmd.op = CMD_READ;
                    KIND_PUT:
                    begin
                        if (status.pad_needed)
                        begin
                            cmd.op = CMD_PUT_START;
                        end
                        else
                        begin
                            cmd.op = CMD_PUT_FINAL;
                            cmd.load_out = status.out_free;
                        end
                    end
                    KIND_DEL:
                    begin
                        if (status.del_needed)
                        begin
                            cmd.op = CMD_DEL_START;
                        end
                        else
                        begin
                            cmd.op = CMD_SIMPLE;
                            cmd.load_out = status.out_free;
                        end
                    end
                    default:
                    begin
                        cmd.op = CMD_SIMPLE;
                        cmd.load_out = status.out_free;
                    end
                endcase
            end
            S_PAD:
            begin
                if (status.pad_more)
                begin
                    cmd.op = CMD_PAD_STEP;
                end
                else
                begin
                    cmd.op = CMD_PUT_FINAL;
                    cmd.load_out = status.out_free;
                end
            end
            S_SHIFT_RD:
            begin
                if (status.shift_more)
                begin
                    cmd.op = CMD_SHIFT_RD;
                end
                else
                begin
                    cmd.op = CMD_DEL_FINAL;
                    cmd.load_out = status.out_free;
                end
            end
            S_SHIFT_WR: cmd.op = CMD_SHIFT_WR;
            S_READ_DATA: cmd.load_out = status.out_free;
            S_WAIT_OUT: cmd.load_out = status.out_free;
            default: cmd.op = CMD_NONE;
        endcase
    end

endmodule

@@ src/ate_datapath.sv @@
module ate_datapath #(
    parameter int ROWS = 32,
    parameter int COLS = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ate_pkg::in_item_t in_data,
    input  ate_pkg::dp_cmd_t  cmd,
    output ate_pkg::dp_status_t status,
    input  logic              out_stall,
    output logic              out_valid,
    output ate_pkg::out_item_t out_data
);

    import ate_pkg::*;

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW = $clog2(COLS);
    localparam int LW = $clog2(COLS + 1);
    localparam int AW = RW + CW;
    localparam int DEPTH = ROWS * (1 << CW);
    localparam logic [16:0] ROW_LIM = 17'(ROWS - 1);
    localparam logic [16:0] COL_LIM = 17'(COLS - 1);

    in_item_t  item_reg, item_next;
    logic [RW-1:0] cur_row_reg, cur_row_next;
    logic [CW-1:0] cur_col_reg, cur_col_next;
    mode_t     mode_reg, mode_next;
    logic [15:0] p1_reg, p1_next;
    logic [15:0] p2_reg, p2_next;
    logic [2:0]  prog_reg, prog_next;
    logic [3:0]  fg_reg, fg_next;
    logic [3:0]  bg_reg, bg_next;
    logic [LW-1:0] cnt_reg, cnt_next;
    logic [LW-1:0] dn_reg, dn_next;
    logic [LW-1:0] newlen_reg, newlen_next;
    logic        present_reg, present_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_data_reg, out_data_next;
    logic [LW-1:0] len_reg [ROWS];

    logic          len_we;
    logic          len_clr;
    logic [LW-1:0] len_wval;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;

    logic [7:0]    b;
    logic          is_letter;
    logic          is_digit;
    logic          is_print;
    logic          rd_in_range;
    logic [RW-1:0] lrow;
    logic [LW-1:0] len_cur;
    logic [LW-1:0] col_w;
    logic          has1;
    logic          has2;
    logic [15:0]   p1m;
    logic [15:0]   p2m;
    logic [15:0]   p1z;
    logic [7:0]    put_ch;
    logic [16:0]   tcol;
    logic [1:0]    parts;
    logic          stopped;
    logic [LW-1:0] rest;
    logic [LW-1:0] dn_calc;
    logic [LW:0]   src_col;
    kind_t         kind;

    function automatic logic [15:0] add_digit(input logic [15:0] p, input logic [3:0] d);
        logic [19:0] t;
        begin
            t = 20'({p, 3'b000}) + 20'({p, 1'b0}) + 20'(d);
            return (t > 20'(PARAM_MAX)) ? PARAM_MAX : t[15:0];
        end
    endfunction

    function automatic logic [16:0] sat_lim(input logic [16:0] v, input logic [16:0] lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic logic [16:0] dec_sat(input logic [15:0] v);
        return (v == 16'd0) ? 17'd0 : 17'(v) - 17'd1;
    endfunction

    ate_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign b = item_reg.rx_byte;
    assign is_letter = (b inside {[CH_UA:CH_UZ], [CH_LA:CH_LZ]});
    assign is_digit = (b inside {[CH_0:CH_9]});
    assign is_print = (b inside {[CH_SPACE:CH_TILDE]});
    assign rd_in_range = (32'(item_reg.read_row) < ROWS) && (32'(item_reg.read_col) < COLS);
    assign lrow = item_reg.op ? (rd_in_range ? RW'(item_reg.read_row) : '0) : cur_row_reg;
    assign len_cur = len_reg[lrow];
    assign col_w = LW'(cur_col_reg);
    assign has1 = (prog_reg[1:0] != 2'd0);
    assign has2 = (prog_reg[1:0] >= 2'd2);
    assign p1m = has1 ? p1_reg : 16'd1;
    assign p2m = has2 ? p2_reg : 16'd1;
    assign p1z = has1 ? p1_reg : 16'd0;
    assign put_ch = (b == CH_BS) ? CH_SPACE : b;
    assign rest = len_cur - col_w;
    assign dn_calc = (p1m > 16'(rest)) ? rest : LW'(p1m);
    assign src_col = (LW+1)'(cnt_reg) + (LW+1)'(dn_reg);

    always_comb
    begin
        if (item_reg.op)
        begin
            kind = KIND_READ;
        end
        else if (mode_reg == MODE_NORMAL && (b == CH_BS || is_print))
        begin
            kind = KIND_PUT;
        end
        else if (mode_reg == MODE_CSI && b == CSI_DEL)
        begin
            kind = KIND_DEL;
        end
        else
        begin
            kind = KIND_SIMPLE;
        end
    end

    assign status.kind = kind;
    assign status.pad_needed = (col_w >= len_cur);
    assign status.pad_more = (cnt_reg < col_w);
    assign status.del_needed = (col_w < len_cur);
    assign status.shift_more = (cnt_reg < newlen_reg);
    assign status.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        item_next = item_reg;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        mode_next = mode_reg;
        p1_next = p1_reg;
        p2_next = p2_reg;
        prog_next = prog_reg;
        fg_next = fg_reg;
        bg_next = bg_reg;
        cnt_next = cnt_reg;
        dn_next = dn_reg;
        newlen_next = newlen_reg;
        present_next = present_reg;
        len_we = 1'b0;
        len_clr = 1'b0;
        len_wval = '0;
        ram_we = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re = 1'b0;
        ram_raddr = '0;
        tcol = '0;
        parts = prog_reg[1:0];
        stopped = prog_reg[2];
        case (cmd.op)
            CMD_LATCH: item_next = in_data;
            CMD_READ:
            begin
                ram_re = 1'b1;
                ram_raddr = {RW'(item_reg.read_row), CW'(item_reg.read_col)};
                present_next = rd_in_range && (32'(item_reg.read_col) < 32'(len_cur));
            end
            CMD_PUT_START: cnt_next = len_cur;
            CMD_PAD_STEP:
            begin
                ram_we = 1'b1;
                ram_waddr = {cur_row_reg, CW'(cnt_reg)};
                ram_wdata = {bg_reg, fg_reg, CH_SPACE};
                cnt_next = cnt_reg + LW'(1);
            end
            CMD_PUT_FINAL:
            begin
                ram_we = 1'b1;
                ram_waddr = {cur_row_reg, cur_col_reg};
                ram_wdata = {bg_reg, fg_reg, put_ch};
                if (col_w >= len_cur)
                begin
                    len_we = 1'b1;
                    len_wval = col_w + LW'(1);
                end
                if (b == CH_BS)
                begin
                    cur_col_next = CW'(dec_sat(16'(cur_col_reg)));
                end
                else
                begin
                    cur_col_next = CW'(sat_lim(17'(cur_col_reg) + 17'd1, COL_LIM));
                end
            end
            CMD_DEL_START:
            begin
                dn_next = dn_calc;
                newlen_next = len_cur - dn_calc;
                cnt_next = col_w;
            end
            CMD_SHIFT_RD:
            begin
                ram_re = 1'b1;
                ram_raddr = {cur_row_reg, CW'(src_col)};
            end
            CMD_SHIFT_WR:
            begin
                ram_we = 1'b1;
                ram_waddr = {cur_row_reg, CW'(cnt_reg)};
                ram_wdata = ram_rdata;
                cnt_next = cnt_reg + LW'(1);
            end
            CMD_DEL_FINAL:
            begin
                len_we = 1'b1;
                len_wval = newlen_reg;
                mode_next = MODE_NORMAL;
            end
            CMD_SIMPLE:
            begin
                case (mode_reg)
                    MODE_NORMAL:
                    begin
                        if (b == CH_TAB)
                        begin
                            tcol = (17'(cur_col_reg) + 17'd8) & ~17'd7;
                            cur_col_next = CW'(sat_lim(tcol, COL_LIM));
                        end
                        else if (b == CH_LF)
                        begin
                            cur_row_next = RW'(sat_lim(17'(cur_row_reg) + 17'd1, ROW_LIM));
                        end
                        else if (b == CH_CR)
                        begin
                            cur_col_next = '0;
                        end
                        else if (b == CH_ESC)
                        begin
                            mode_next = MODE_ESC;
                            p1_next = '0;
                            p2_next = '0;
                            prog_next = '0;
                        end
                    end
                    MODE_ESC:
                    begin
                        if (b == CH_LBRACKET)
                        begin
                            mode_next = MODE_CSI;
                        end
                        else if (b == CH_RBRACKET)
                        begin
                            mode_next = MODE_OSC;
                        end
                        else
                        begin
                            mode_next = MODE_NORMAL;
                        end
                    end
                    MODE_CSI:
                    begin
                        if (is_letter)
                        begin
                            mode_next = MODE_NORMAL;
                            case (b)
                                CSI_UP:
                                begin
                                    cur_row_next = (17'(p1m) > 17'(cur_row_reg)) ? '0
                                        : RW'(17'(cur_row_reg) - 17'(p1m));
                                end
                                CSI_DOWN:
                                begin
                                    cur_row_next = RW'(sat_lim(17'(cur_row_reg) + 17'(p1m),
                                        ROW_LIM));
                                end
                                CSI_RIGHT:
                                begin
                                    cur_col_next = CW'(sat_lim(17'(cur_col_reg) + 17'(p1m),
                                        COL_LIM));
                                end
                                CSI_LEFT:
                                begin
                                    cur_col_next = (17'(p1m) > 17'(cur_col_reg)) ? '0
                                        : CW'(17'(cur_col_reg) - 17'(p1m));
                                end
                                CSI_POS:
                                begin
                                    cur_row_next = RW'(sat_lim(dec_sat(p1m), ROW_LIM));
                                    cur_col_next = CW'(sat_lim(dec_sat(p2m), COL_LIM));
                                end
                                CSI_COL: cur_col_next = CW'(sat_lim(dec_sat(p1m), COL_LIM));
                                CSI_ROW: cur_row_next = RW'(sat_lim(dec_sat(p1m), ROW_LIM));
                                CSI_CLEAR:
                                begin
                                    if (p1z == 16'd2)
                                    begin
                                        cur_row_next = '0;
                                        cur_col_next = '0;
                                        len_clr = 1'b1;
                                    end
                                end
                                CSI_ERASE:
                                begin
                                    if (p1z == 16'd0 && col_w < len_cur)
                                    begin
                                        len_we = 1'b1;
                                        len_wval = col_w;
                                    end
                                end
                                CSI_SGR:
                                begin
                                    if (has1)
                                    begin
                                        if (p1_reg == 16'd0)
                                        begin
                                            fg_next = COLOUR_DEFAULT;
                                            bg_next = COLOUR_DEFAULT;
                                        end
                                        else if (p1_reg inside {[16'd30:16'd39]})
                                        begin
                                            fg_next = 4'(p1_reg - 16'd30);
                                        end
                                        else if (p1_reg inside {[16'd40:16'd49]})
                                        begin
                                            bg_next = 4'(p1_reg - 16'd40);
                                        end
                                    end
                                end
                                default: mode_next = MODE_NORMAL;
                            endcase
                        end
                        else
                        begin
                            if (b == CH_SEMI)
                            begin
                                if (parts == 2'd0)
                                begin
                                    parts = 2'd2;
                                end
                                else if (parts != 2'd3)
                                begin
                                    parts = parts + 2'd1;
                                end
                                stopped = 1'b0;
                            end
                            else
                            begin
                                if (parts == 2'd0)
                                begin
                                    parts = 2'd1;
                                end
                                if (is_digit && !stopped)
                                begin
                                    if (parts == 2'd1)
                                    begin
                                        p1_next = add_digit(p1_reg, 4'(b - CH_0));
                                    end
                                    else if (parts == 2'd2)
                                    begin
                                        p2_next = add_digit(p2_reg, 4'(b - CH_0));
                                    end
                                end
                                else if (!is_digit)
                                begin
                                    stopped = 1'b1;
                                end
                            end
                            prog_next = {stopped, parts};
                        end
                    end
                    default:
                    begin
                        if (b == CH_BEL)
                        begin
                            mode_next = MODE_NORMAL;
                        end
                    end
                endcase
            end
            default: item_next = item_reg;
        endcase
    end

    always_comb
    begin
        out_data_next = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next.cursor_row = 5'(cur_row_next);
            out_data_next.cursor_col = 7'(cur_col_next);
            out_data_next.parse_state = mode_next;
            out_data_next.cell_char = '0;
            out_data_next.cell_fg = '0;
            out_data_next.cell_bg = '0;
            out_data_next.cell_present = 1'b0;
            if (item_reg.op && present_reg)
            begin
                out_data_next.cell_char = ram_rdata[7:0];
                out_data_next.cell_fg = colour_rgb(ram_rdata[11:8], 1'b1);
                out_data_next.cell_bg = colour_rgb(ram_rdata[15:12], 1'b0);
                out_data_next.cell_present = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            mode_reg <= MODE_NORMAL;
            p1_reg <= '0;
            p2_reg <= '0;
            prog_reg <= '0;
            fg_reg <= COLOUR_DEFAULT;
            bg_reg <= COLOUR_DEFAULT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            mode_reg <= mode_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            prog_reg <= prog_next;
            fg_reg <= fg_next;
            bg_reg <= bg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        cnt_reg <= cnt_next;
        dn_reg <= dn_next;
        newlen_reg <= newlen_next;
        present_reg <= present_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROWS; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else if (len_clr)
        begin
            for (int i = 0; i < ROWS; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else if (len_we)
        begin
            len_reg[cur_row_reg] <= len_wval;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

endmodule

@@ src/ansi_terminal_escape_engine_top.sv @@
// text terminal engine: byte parser, cursor and a ROWS x COLS cell store
// input channel (in_valid/in_stall/in_data): op 0 feeds one host byte, op 1
// reads one screen cell; one result beat leaves on out_valid/out_stall/out_data
// for every input beat, in order, with the cursor and parser state after it
// one item is taken at a time; the controller walks each item through the
// datapath and the cell memory, which has one write port and one read port
// control bytes, escapes and in-line characters finish in the dispatch state;
// a cell read adds a read-data state for the registered memory read; a
// character past the line end adds one pad write per cell of the gap;
// a delete adds a read then a write per shifted cell
// the input takes a new beat in the cycle after the result is loaded
// the output register holds a finished result while the receiver stalls and
// the next item is already accepted; that item finishes only once the
// register is free
// reset clears the cursor, parser and all line lengths and restores default colours at once;
// the cell memory needs no clearing since only cells below a line length
// are ever read
module ansi_terminal_escape_engine_top #(
    parameter int ROWS = ate_pkg::ROWS_DEF,
    parameter int COLS = ate_pkg::COLS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ate_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output ate_pkg::out_item_t out_data
);

    import ate_pkg::*;

`include "ansi_terminal_escape_engine_top_defines.svh"

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       absent_blank;

    ate_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ate_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign absent_blank = (out_data.cell_char == 8'd0) && (out_data.cell_fg == 24'd0);

    `ATE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    `ATE_ASSERT_IMPLY(a_row_in_range, clk, rst_n, out_valid, 32'(out_data.cursor_row) < ROWS)
    `ATE_ASSERT_IMPLY(a_absent_blank, clk, rst_n, out_valid && !out_data.cell_present, absent_blank)

endmodule
